FILE: sv/fprl_pkg.sv
package fprl_pkg;

	// Defaults for the top-level parameters
	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 16;

	// Fixed field widths of the result
	localparam int OUT_FRAME_W = 4;
	localparam int OUT_PAGE_W  = 16;
	localparam int TOTAL_W     = 32;

	// Configuration port
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'd1;
	localparam logic [CFG_W-1:0] FRAMES_RST = 5'd16;

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	localparam logic ACT_ACCESS = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SEARCH,
		B_EVICT
	} back_state_t;

	// Head of the queue between front and back
	typedef struct packed {
		logic valid;
		logic clear;
	} q_head_t;

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
		return (v == '1) ? v : v + TOTAL_W'(1);
	endfunction

endpackage

FILE: sv/fifo_lru_page_replacement_unit.sv
// Fully associative page-frame tracker with FIFO or LRU replacement.
//
// Input: pulse start with action and page_number; the item is taken at the
// edge where start is high and busy is low. busy rises only when the
// two-entry queue between the front and the back is full.
// Result: one transfer per item, on the cycle done is high; the receiver
// cannot stall, so every result shows for exactly one cycle.
// Flow: an accepted item waits in the queue; the back then takes it, acts
// and registers the result together with done. A hit, a fill of a free
// frame or a clear is settled straight from idle; an eviction first walks
// the stamps one frame per cycle over the first n frames to find the
// oldest, n being frames_in_use held to 1 .. FRAMES, then writes the
// victim frame. While the back searches, the front still takes new items
// until the queue is full.
// Configuration: wr_en/wr_index/wr_data write policy_mode (index 0) and
// frames_in_use (index 1); write only while the block is idle.
// Reset: all frames empty, time and totals zero, FIFO policy, all frames
// in use. Frame contents and stamps are left as they are until written.
module fifo_lru_page_replacement_unit import fprl_pkg::*; #(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_IDX_W-1:0]   wr_index,
	input  logic [CFG_W-1:0]       wr_data,
	input  logic                   start,
	output logic                   busy,
	input  logic                   action,
	input  logic [PAGE_BITS-1:0]   page_number,
	output logic                   done,
	output logic                   was_hit,
	output logic [OUT_FRAME_W-1:0] frame_used,
	output logic                   evicted_valid,
	output logic [OUT_PAGE_W-1:0]  evicted_page,
	output logic [TOTAL_W-1:0]     fault_total,
	output logic [TOTAL_W-1:0]     hit_total,
	output logic [TOTAL_W-1:0]     access_total
);

	logic                 policy_q;
	logic [CFG_W-1:0]     frames_q;
	q_head_t              head;
	logic [PAGE_BITS-1:0] head_page;
	logic                 pop;

	// Configuration registers; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_FIFO;
			frames_q <= FRAMES_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_POLICY: policy_q <= wr_data[0];
				REG_FRAMES: frames_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Front: accept, decode the action and hold the item in the queue
	fprl_front #(
		.PAGE_BITS(PAGE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.action     (action),
		.page_number(page_number),
		.busy       (busy),
		.pop        (pop),
		.head       (head),
		.head_page  (head_page)
	);

	// Back: look up, pick a victim and update frames and totals
	fprl_back #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.policy_mode  (policy_q),
		.frames_in_use(frames_q),
		.head         (head),
		.head_page    (head_page),
		.pop          (pop),
		.done         (done),
		.was_hit      (was_hit),
		.frame_used   (frame_used),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.fault_total  (fault_total),
		.hit_total    (hit_total),
		.access_total (access_total)
	);

	// A hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(was_hit && evicted_valid))
		else $error("hit result reports an eviction");

	// Hits and faults never outrun accesses
	a_totals_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hit_total <= access_total) && (fault_total <= access_total))
		else $error("hit or fault total exceeds access total");

	// An eviction is always a fault
	a_evict_is_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done && evicted_valid |-> fault_total != '0)
		else $error("eviction reported with zero faults");

	// The back only takes an item that the front holds
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue popped while empty");

endmodule

FILE: sv/fprl_front.sv
module fprl_front import fprl_pkg::*; #(
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 action,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic                 busy,
	input  logic                 pop,
	output q_head_t              head,
	output logic [PAGE_BITS-1:0] head_page
);

	// Two-entry queue of decoded items
	logic                 clear_q [2];
	logic [PAGE_BITS-1:0] page_q  [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 push;

	assign busy = (count_q == 2'd2);
	assign push = start && !busy;

	assign head.valid = (count_q != 2'd0);
	assign head.clear = clear_q[rd_ptr_q];
	assign head_page  = page_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			clear_q[wr_ptr_q] <= (action == ACT_CLEAR);
			page_q[wr_ptr_q]  <= page_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

FILE: sv/fprl_back.sv
module fprl_back import fprl_pkg::*; #(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   policy_mode,
	input  logic [CFG_W-1:0]       frames_in_use,
	input  q_head_t                head,
	input  logic [PAGE_BITS-1:0]   head_page,
	output logic                   pop,
	output logic                   done,
	output logic                   was_hit,
	output logic [OUT_FRAME_W-1:0] frame_used,
	output logic                   evicted_valid,
	output logic [OUT_PAGE_W-1:0]  evicted_page,
	output logic [TOTAL_W-1:0]     fault_total,
	output logic [TOTAL_W-1:0]     hit_total,
	output logic [TOTAL_W-1:0]     access_total
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int N_W   = $clog2(FRAMES + 1);

	back_state_t state_q, state_d;

	logic [PAGE_BITS-1:0] frame_page_q [FRAMES];
	logic [TOTAL_W-1:0]   load_stamp_q [FRAMES];
	logic [TOTAL_W-1:0]   use_stamp_q  [FRAMES];
	logic [FRAMES-1:0]    valid_q;

	logic [TOTAL_W-1:0] time_q, fault_q, hit_q, access_q;
	logic [TOTAL_W-1:0] time_d, fault_d, hit_d, access_d;

	logic [PAGE_BITS-1:0] page_q;
	logic [IDX_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [TOTAL_W-1:0]   best_q;

	logic [N_W-1:0]    n;
	logic [FRAMES-1:0] hit_vec, free_vec;
	logic [IDX_W-1:0]  hit_idx, free_idx;
	logic              hit_any, free_any;
	logic [TOTAL_W-1:0] stamp_first, stamp_cand;
	logic              last_step;

	logic do_clear, do_hit, do_fill, do_search, do_step, do_evict;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [PAGE_BITS-1:0] wr_page;
	logic [TOTAL_W-1:0] wr_time;
	logic [IDX_W-1:0]  res_idx;

	logic                   done_q, was_hit_q, ev_valid_q;
	logic [OUT_FRAME_W-1:0] frame_used_q;
	logic [OUT_PAGE_W-1:0]  ev_page_q;
	logic [TOTAL_W-1:0]     fault_tot_q, hit_tot_q, access_tot_q;

	// Clamp the frame count to 1 .. FRAMES
	always_comb begin
		if (frames_in_use == '0)
			n = N_W'(1);
		else if (int'(frames_in_use) > FRAMES)
			n = N_W'(FRAMES);
		else
			n = N_W'(frames_in_use);
	end

	// Parallel tag compare and lowest-index pick
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			hit_vec[i]  = valid_q[i] && (frame_page_q[i] == head_page) && (N_W'(i) < n);
			free_vec[i] = !valid_q[i] && (N_W'(i) < n);
		end
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (hit_vec[i])
				hit_idx = IDX_W'(i);
			if (free_vec[i])
				free_idx = IDX_W'(i);
		end
		hit_any  = |hit_vec;
		free_any = |free_vec;
	end

	assign stamp_first = (policy_mode == POLICY_LRU) ? use_stamp_q[0] : load_stamp_q[0];
	assign stamp_cand  = (policy_mode == POLICY_LRU) ? use_stamp_q[cnt_q] : load_stamp_q[cnt_q];
	assign last_step   = (N_W'(cnt_q) == n - N_W'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (do_search)
					state_d = (n == N_W'(1)) ? B_EVICT : B_SEARCH;
			end
			B_SEARCH: begin
				if (last_step)
					state_d = B_EVICT;
			end
			B_EVICT: state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		do_clear  = 1'b0;
		do_hit    = 1'b0;
		do_fill   = 1'b0;
		do_search = 1'b0;
		do_step   = 1'b0;
		do_evict  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (head.clear)
						do_clear = 1'b1;
					else if (hit_any)
						do_hit = 1'b1;
					else if (free_any)
						do_fill = 1'b1;
					else
						do_search = 1'b1;
				end
			end
			B_SEARCH: do_step  = 1'b1;
			B_EVICT:  do_evict = 1'b1;
			default: ;
		endcase

		time_d   = time_q;
		fault_d  = fault_q;
		hit_d    = hit_q;
		access_d = access_q;
		if (do_clear) begin
			time_d   = '0;
			fault_d  = '0;
			hit_d    = '0;
			access_d = '0;
		end
		if (do_hit || do_fill || do_search) begin
			time_d   = sat_inc(time_q);
			access_d = sat_inc(access_q);
		end
		if (do_hit)
			hit_d = sat_inc(hit_q);
		if (do_fill || do_evict)
			fault_d = sat_inc(fault_q);

		wr_en   = do_fill || do_evict;
		wr_idx  = do_evict ? best_idx_q : free_idx;
		wr_page = do_evict ? page_q : head_page;
		wr_time = time_d;

		if (do_hit)
			res_idx = hit_idx;
		else if (do_fill)
			res_idx = free_idx;
		else if (do_evict)
			res_idx = best_idx_q;
		else
			res_idx = '0;
	end

	// Frame store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_page_q[wr_idx] <= wr_page;
			load_stamp_q[wr_idx] <= wr_time;
			use_stamp_q[wr_idx]  <= wr_time;
		end else if (do_hit && policy_mode == POLICY_LRU) begin
			use_stamp_q[hit_idx] <= time_d;
		end
	end

	// Victim search and result payload
	always_ff @(posedge clk) begin
		if (do_search) begin
			page_q     <= head_page;
			best_q     <= stamp_first;
			best_idx_q <= '0;
			cnt_q      <= IDX_W'(1);
		end else if (do_step) begin
			if (stamp_cand < best_q) begin
				best_q     <= stamp_cand;
				best_idx_q <= cnt_q;
			end
			cnt_q <= cnt_q + IDX_W'(1);
		end
		if (do_clear || do_hit || do_fill || do_evict) begin
			was_hit_q    <= do_hit;
			frame_used_q <= OUT_FRAME_W'(res_idx);
			ev_valid_q   <= do_evict;
			ev_page_q    <= do_evict ? OUT_PAGE_W'(frame_page_q[best_idx_q]) : '0;
			fault_tot_q  <= fault_d;
			hit_tot_q    <= hit_d;
			access_tot_q <= access_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			valid_q  <= '0;
			time_q   <= '0;
			fault_q  <= '0;
			hit_q    <= '0;
			access_q <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			time_q   <= time_d;
			fault_q  <= fault_d;
			hit_q    <= hit_d;
			access_q <= access_d;
			done_q   <= do_clear || do_hit || do_fill || do_evict;
			if (do_clear)
				valid_q <= '0;
			else if (wr_en)
				valid_q[wr_idx] <= 1'b1;
		end
	end

	assign done          = done_q;
	assign was_hit       = was_hit_q;
	assign frame_used    = frame_used_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_total   = fault_tot_q;
	assign hit_total     = hit_tot_q;
	assign access_total  = access_tot_q;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

typedef struct packed {
	logic                                   was_hit;
	logic [fprl_pkg::OUT_FRAME_W-1:0] frame_used;
	logic                                   evicted_valid;
	logic [fprl_pkg::OUT_PAGE_W-1:0]  evicted_page;
	logic [fprl_pkg::TOTAL_W-1:0]     fault_total;
	logic [fprl_pkg::TOTAL_W-1:0]     hit_total;
	logic [fprl_pkg::TOTAL_W-1:0]     access_total;
} frame_result_t;

class page_frame_scoreboard;
	localparam int NFR = fprl_pkg::FRAMES_DEF;

	bit [15:0]     page_tab[NFR];
	bit            resident[NFR];
	bit [31:0]     load_stamp[NFR];
	bit [31:0]     use_stamp[NFR];
	bit [31:0]     clock_now;
	bit [31:0]     faults;
	bit [31:0]     hits;
	bit [31:0]     accesses;
	bit            lru_mode;
	bit [4:0]      frame_limit;
	frame_result_t outcome_q[$];
	int            errors;

	function new();
		wipe();
		lru_mode    = fprl_pkg::POLICY_FIFO;
		frame_limit = fprl_pkg::FRAMES_RST;
		errors      = 0;
	endfunction

	function bit [31:0] sat_step(bit [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function void wipe();
		for (int i = 0; i < NFR; i++) begin
			page_tab[i]   = '0;
			resident[i]   = 1'b0;
			load_stamp[i] = '0;
			use_stamp[i]  = '0;
		end
		clock_now = '0;
		faults    = '0;
		hits      = '0;
		accesses  = '0;
	endfunction

	function void write_reg(logic [fprl_pkg::CFG_IDX_W-1:0] idx,
			logic [fprl_pkg::CFG_W-1:0] data);
		if (idx == fprl_pkg::REG_POLICY)
			lru_mode = data[0];
		else if (idx == fprl_pkg::REG_FRAMES)
			frame_limit = data;
	endfunction

	// Work out the result of one accepted transfer and queue it.
	function void note_item(logic act, logic [15:0] page);
		int            n;
		int            slot;
		bit [31:0]     oldest;
		bit [31:0]     stamp_i;
		frame_result_t r;
		r = '0;
		if (act == fprl_pkg::ACT_CLEAR) begin
			wipe();
		end else begin
			n = (frame_limit == 0) ? 1 : ((frame_limit > NFR) ? NFR : frame_limit);
			clock_now = sat_step(clock_now);
			accesses  = sat_step(accesses);
			slot = -1;
			for (int i = 0; i < n; i++)
				if (slot < 0 && resident[i] && page_tab[i] == page)
					slot = i;
			if (slot >= 0) begin
				r.was_hit = 1'b1;
				hits = sat_step(hits);
				if (lru_mode)
					use_stamp[slot] = clock_now;
			end else begin
				faults = sat_step(faults);
				for (int i = 0; i < n; i++)
					if (slot < 0 && !resident[i])
						slot = i;
				if (slot < 0) begin
					// every searched frame is full: oldest stamp wins, ties to low index
					slot   = 0;
					oldest = lru_mode ? use_stamp[0] : load_stamp[0];
					for (int i = 1; i < n; i++) begin
						stamp_i = lru_mode ? use_stamp[i] : load_stamp[i];
						if (stamp_i < oldest) begin
							oldest = stamp_i;
							slot   = i;
						end
					end
					r.evicted_valid = 1'b1;
					r.evicted_page  = page_tab[slot];
				end
				page_tab[slot]   = page;
				resident[slot]   = 1'b1;
				load_stamp[slot] = clock_now;
				use_stamp[slot]  = clock_now;
			end
			r.frame_used = slot[3:0];
		end
		r.fault_total  = faults;
		r.hit_total    = hits;
		r.access_total = accesses;
		outcome_q.push_back(r);
	endfunction

	function void cmp(string field, longint unsigned want, longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		end
	endfunction

	function void check_result(frame_result_t got);
		frame_result_t want;
		if (outcome_q.size() == 0) begin
			errors++;
			$display("%0t: result with none expected, got %p", $time, got);
			return;
		end
		want = outcome_q.pop_front();
		cmp("was_hit", want.was_hit, got.was_hit);
		cmp("frame_used", want.frame_used, got.frame_used);
		cmp("evicted_valid", want.evicted_valid, got.evicted_valid);
		cmp("evicted_page", want.evicted_page, got.evicted_page);
		cmp("fault_total", want.fault_total, got.fault_total);
		cmp("hit_total", want.hit_total, got.hit_total);
		cmp("access_total", want.access_total, got.access_total);
	endfunction

	function int pending();
		return outcome_q.size();
	endfunction
endclass

module tb_top;
	import fprl_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 34;

	logic                   clk;
	logic                   arst_n;
	logic                   wr_en;
	logic [CFG_IDX_W-1:0]   wr_index;
	logic [CFG_W-1:0]       wr_data;
	logic                   start;
	logic                   busy;
	logic                   action;
	logic [PAGE_BITS_DEF-1:0] page_number;
	logic                   done;
	logic                   was_hit;
	logic [OUT_FRAME_W-1:0] frame_used;
	logic                   evicted_valid;
	logic [OUT_PAGE_W-1:0]  evicted_page;
	logic [TOTAL_W-1:0]     fault_total;
	logic [TOTAL_W-1:0]     hit_total;
	logic [TOTAL_W-1:0]     access_total;

	page_frame_scoreboard sb;
	int  cycles;
	bit  no_gaps;

	fifo_lru_page_replacement_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.page_number  (page_number),
		.done         (done),
		.was_hit      (was_hit),
		.frame_used   (frame_used),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.fault_total  (fault_total),
		.hit_total    (hit_total),
		.access_total (access_total)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("fifo_lru_page_replacement_unit test failed");
			$finish;
		end
	end

	// Result side: done is a one-cycle strobe, so check every flagged cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{was_hit, frame_used, evicted_valid, evicted_page,
				fault_total, hit_total, access_total});
	end

	// Drive one transfer. Start is left high on return so back-to-back
	// transfers never drop it; a gap lowers it on its own falling edge.
	task automatic send(input logic act, input logic [15:0] page);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start       <= 1'b1;
		action      <= act;
		page_number <= page;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		sb.note_item(act, page);
	endtask

	// Hold off the sender until every outstanding result has come back.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Registers only change with the block idle.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		drain();
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	logic [15:0] pool[20];
	bit          phase_lru[PHASES]    = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
		1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
	bit [4:0]    phase_frames[PHASES] = '{5'd16, 5'd16, 5'd1, 5'd1, 5'd4, 5'd4,
		5'd0, 5'd31, 5'd17, 5'd8, 5'd3, 5'd2};

	initial begin
		int eff;
		int pool_size;
		int pause_at;
		int roll;
		sb          = new();
		cycles      = 0;
		no_gaps     = 1'b0;
		arst_n      = 1'b0;
		wr_en       = 1'b0;
		wr_index    = REG_POLICY;
		wr_data     = '0;
		start       = 1'b0;
		action      = ACT_ACCESS;
		page_number = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed: page extremes, a hit, a clear on reset defaults.
		send(ACT_ACCESS, 16'h0000);
		send(ACT_ACCESS, 16'hFFFF);
		send(ACT_ACCESS, 16'h0000);
		send(ACT_ACCESS, 16'hAAAA);
		send(ACT_ACCESS, 16'h5555);
		send(ACT_CLEAR, 16'hFFFF);

		// Frame count of zero behaves as a single frame.
		set_reg(REG_FRAMES, 5'd0);
		set_reg(REG_POLICY, CFG_W'(POLICY_LRU));
		send(ACT_ACCESS, 16'd1);
		send(ACT_ACCESS, 16'd2);
		send(ACT_ACCESS, 16'd2);

		// Two frames under LRU: a hit refreshes the use stamp.
		set_reg(REG_FRAMES, 5'd2);
		no_gaps = 1'b1;
		send(ACT_ACCESS, 16'd10);
		send(ACT_ACCESS, 16'd20);
		send(ACT_ACCESS, 16'd10);
		send(ACT_ACCESS, 16'd30);
		send(ACT_ACCESS, 16'd10);
		send(ACT_ACCESS, 16'd40);
		no_gaps = 1'b0;

		// Same pattern under FIFO evicts by load order instead.
		set_reg(REG_POLICY, CFG_W'(POLICY_FIFO));
		send(ACT_CLEAR, 16'd0);
		send(ACT_ACCESS, 16'd10);
		send(ACT_ACCESS, 16'd20);
		send(ACT_ACCESS, 16'd10);
		send(ACT_ACCESS, 16'd30);

		// Shrink the frame count mid-run, then grow it back: the hidden
		// frames keep their pages and become searchable again.
		set_reg(REG_FRAMES, 5'd4);
		send(ACT_ACCESS, 16'd1);
		send(ACT_ACCESS, 16'd2);
		send(ACT_ACCESS, 16'd3);
		send(ACT_ACCESS, 16'd4);
		set_reg(REG_FRAMES, 5'd2);
		send(ACT_ACCESS, 16'd3);
		set_reg(REG_FRAMES, 5'd4);
		send(ACT_ACCESS, 16'd4);

		// Random phases, one setting each; pages mostly come from a small
		// working set so hits and evictions are both frequent.
		for (int p = 0; p < PHASES; p++) begin
			set_reg(REG_POLICY, CFG_W'(phase_lru[p]));
			set_reg(REG_FRAMES, phase_frames[p]);
			eff = (phase_frames[p] == 0) ? 1 : ((phase_frames[p] > 16) ? 16 : phase_frames[p]);
			pool_size = eff + $urandom_range(0, 4);
			if (pool_size > 20)
				pool_size = 20;
			for (int k = 0; k < 20; k++)
				pool[k] = 16'($urandom);
			no_gaps  = ($urandom_range(0, 3) == 0);
			pause_at = $urandom_range(5, PHASE_ITEMS - 5);
			if ($urandom_range(0, 1) == 0)
				send(ACT_CLEAR, 16'($urandom));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == pause_at)
					drain();
				roll = $urandom_range(0, 99);
				if (roll < 3)
					send(ACT_CLEAR, 16'($urandom));
				else if (roll < 8)
					send(ACT_ACCESS, 16'($urandom));
				else
					send(ACT_ACCESS, pool[$urandom_range(0, pool_size - 1)]);
			end
		end

		drain();
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("fifo_lru_page_replacement_unit test passed");
		else
			$display("fifo_lru_page_replacement_unit test failed");
		$finish;
	end

endmodule

FILE: sim.f
sv/fprl_pkg.sv
sv/fprl_front.sv
sv/fprl_back.sv
sv/fifo_lru_page_replacement_unit.sv
sim/tb_top.sv
